/* rtl/tmr_pkg.sv */
// Shared types, codes and helpers for the divider timer.
package tmr_pkg;

    localparam logic [15:0] CLOCK_RESET = 16'hA700;
    localparam logic [15:0] CLOCK_STEP  = 16'd4;
    localparam int          ENABLE_IDX  = 2;
    localparam logic [7:0]  COUNT_MAX   = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ADDR_DIV  = 2'd0,
        ADDR_CNT  = 2'd1,
        ADDR_MOD  = 2'd2,
        ADDR_CTRL = 2'd3
    } addr_t;

    typedef enum logic [1:0] {
        MODE_BIT9 = 2'd0,
        MODE_BIT3 = 2'd1,
        MODE_BIT5 = 2'd2,
        MODE_BIT7 = 2'd3
    } mode_t;

    typedef struct packed {
        op_t        op;
        addr_t      addr;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic       timer_interrupt;
        logic [7:0] read_data;
    } result_t;

    // Returns the clock bit that the mode field of a control byte selects.
    function automatic logic sel_bit(input logic [15:0] clk, input logic [7:0] ctrl);
        logic bit_val;
        case (mode_t'(ctrl[1:0]))
            MODE_BIT9: bit_val = clk[9];
            MODE_BIT3: bit_val = clk[3];
            MODE_BIT5: bit_val = clk[5];
            MODE_BIT7: bit_val = clk[7];
            default:   bit_val = 1'b0;
        endcase
        return bit_val;
    endfunction

endpackage

/* rtl/tmr_core.sv */
// Timer state registers and the single-pass update for one item.
module tmr_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  tmr_pkg::item_t   item,
    output tmr_pkg::result_t res
);

    logic [15:0] clock_reg, clock_next;
    logic [7:0]  counter_reg, counter_next;
    logic [7:0]  modulo_reg, modulo_next;
    logic [7:0]  control_reg, control_next;
    logic        pending_reg, pending_next;

    logic [15:0] clock_step;
    logic [7:0]  cnt_base;
    logic        pend_base;
    logic        bump;
    logic        enabled;

    assign enabled    = control_reg[tmr_pkg::ENABLE_IDX];
    assign clock_step = clock_reg + tmr_pkg::CLOCK_STEP;

    always_comb begin
        clock_next          = clock_reg;
        modulo_next         = modulo_reg;
        control_next        = control_reg;
        cnt_base            = counter_reg;
        pend_base           = pending_reg;
        bump                = 1'b0;
        res.read_data       = 8'd0;
        res.timer_interrupt = 1'b0;
        case (item.op)
            tmr_pkg::OP_TICK: begin
                if (pending_reg) begin
                    pend_base           = 1'b0;
                    cnt_base            = modulo_reg;
                    res.timer_interrupt = 1'b1;
                end
                bump = enabled && tmr_pkg::sel_bit(clock_reg, control_reg)
                       && !tmr_pkg::sel_bit(clock_step, control_reg);
                clock_next = clock_step;
            end
            tmr_pkg::OP_READ: begin
                case (item.addr)
                    tmr_pkg::ADDR_DIV:  res.read_data = clock_reg[15:8];
                    tmr_pkg::ADDR_CNT:  res.read_data = counter_reg;
                    tmr_pkg::ADDR_MOD:  res.read_data = modulo_reg;
                    tmr_pkg::ADDR_CTRL: res.read_data = control_reg;
                    default:            res.read_data = 8'd0;
                endcase
            end
            tmr_pkg::OP_WRITE: begin
                case (item.addr)
                    tmr_pkg::ADDR_DIV: begin
                        clock_next = 16'd0;
                        bump = enabled && tmr_pkg::sel_bit(clock_reg, control_reg);
                    end
                    tmr_pkg::ADDR_CNT:  cnt_base    = item.write_data;
                    tmr_pkg::ADDR_MOD:  modulo_next = item.write_data;
                    tmr_pkg::ADDR_CTRL: begin
                        control_next = item.write_data;
                        bump = enabled && tmr_pkg::sel_bit(clock_reg, control_reg)
                               && !tmr_pkg::sel_bit(clock_reg, item.write_data);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        counter_next = cnt_base;
        pending_next = pend_base;
        if (bump) begin
            if (cnt_base == tmr_pkg::COUNT_MAX) begin
                counter_next = 8'd0;
                pending_next = 1'b1;
            end else begin
                counter_next = cnt_base + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg   <= tmr_pkg::CLOCK_RESET;
            counter_reg <= 8'd0;
            modulo_reg  <= 8'd0;
            control_reg <= 8'd0;
            pending_reg <= 1'b0;
        end else if (fire) begin
            clock_reg   <= clock_next;
            counter_reg <= counter_next;
            modulo_reg  <= modulo_next;
            control_reg <= control_next;
            pending_reg <= pending_next;
        end
    end

`ifndef SYNTHESIS
    a_tick_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.op == tmr_pkg::OP_TICK && pending_reg |-> res.timer_interrupt)
        else $error("Pending overflow did not raise the interrupt on a tick.");

    a_div_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.op == tmr_pkg::OP_WRITE && item.addr == tmr_pkg::ADDR_DIV
        |=> clock_reg == 16'd0)
        else $error("Divider write did not clear the clock.");

    a_tick_step: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.op == tmr_pkg::OP_TICK
        |=> clock_reg == $past(clock_reg) + tmr_pkg::CLOCK_STEP)
        else $error("Tick did not advance the clock by one step.");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(counter_reg) && $stable(pending_reg) && $stable(clock_reg))
        else $error("Timer state changed without an item.");
`endif

endmodule

/* rtl/divider_timer_with_edge_glitches.sv */
// A result passes the input register and then the result register before it is valid; a stall on
// m_tready can hold it in either. Throughput: one item per clock while m_tready is high; the input
// register refills while the result register drains.
// s_tready drops only when both stages hold items and the downstream side is not ready.
// Reset: synchronous active-low aresetn empties both stages and sets the clock to 0xA700,
// with counter, modulo, control and the pending overflow cleared.
module divider_timer_with_edge_glitches (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // address [1:0], write_data [9:2], zero [15:10]
    input  logic [1:0]  s_tuser,  // operation [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // read_data [7:0], timer_interrupt [8], zero [15:9]
);

    logic             in_valid_reg, in_valid_next;
    tmr_pkg::item_t   in_item_reg;
    logic             out_valid_reg, out_valid_next;
    tmr_pkg::result_t out_res_reg;
    tmr_pkg::result_t core_res;
    logic             advance;
    logic             fire;
    logic             s_accept;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.op         <= tmr_pkg::op_t'(s_tuser);
            in_item_reg.addr       <= tmr_pkg::addr_t'(s_tdata[1:0]);
            in_item_reg.write_data <= s_tdata[9:2];
        end
        if (fire) begin
            out_res_reg <= core_res;
        end
    end

    tmr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .res     (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.timer_interrupt, out_res_reg.read_data};

endmodule

/* test/divider_timer_with_edge_glitches_tb.sv */
// Testbench for the divider timer: directed and random register and tick traffic checked against a predictor.
`timescale 1ns / 100ps

module divider_timer_with_edge_glitches_tb;
    import tmr_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         RANDOM_ITEMS = 2000;
    localparam int         MAX_WAIT     = 11;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Predicted timer state.
    logic [15:0] clock_q;
    logic [7:0]  counter_q;
    logic [7:0]  modulo_q;
    logic [7:0]  control_q;
    logic        pending_q;

    result_t     expected_results[$];
    int          error_count = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          interrupts_seen = 0;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;

    divider_timer_with_edge_glitches u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int mode_index(input logic [7:0] ctl);
        case (mode_t'(ctl[1:0]))
            MODE_BIT9: return 9;
            MODE_BIT3: return 3;
            MODE_BIT5: return 5;
            default:   return 7;
        endcase
    endfunction

    function automatic logic watched_bit(input logic [15:0] clk, input logic [7:0] ctl);
        return clk[mode_index(ctl)];
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic reset_timer_model();
        clock_q   = CLOCK_RESET;
        counter_q = '0;
        modulo_q  = '0;
        control_q = '0;
        pending_q = 1'b0;
    endtask

    task automatic step_counter();
        if (counter_q == COUNT_MAX) begin
            counter_q = '0;
            pending_q = 1'b1;
        end else begin
            counter_q = counter_q + 8'd1;
        end
    endtask

    task automatic predict_timer(input logic [1:0] op, input addr_t addr,
                                 input logic [7:0] data, output result_t res);
        logic [15:0] next_clock;
        logic [15:0] old_clock;
        logic [7:0]  old_control;
        res = '0;
        case (op)
            OP_TICK: begin
                if (pending_q) begin
                    pending_q = 1'b0;
                    res.timer_interrupt = 1'b1;
                    counter_q = modulo_q;
                end
                next_clock = clock_q + CLOCK_STEP;
                if (control_q[ENABLE_IDX] && watched_bit(clock_q, control_q)
                        && !watched_bit(next_clock, control_q))
                    step_counter();
                clock_q = next_clock;
            end
            OP_READ: begin
                case (addr)
                    ADDR_DIV: res.read_data = clock_q[15:8];
                    ADDR_CNT: res.read_data = counter_q;
                    ADDR_MOD: res.read_data = modulo_q;
                    default:  res.read_data = control_q;
                endcase
            end
            OP_WRITE: begin
                case (addr)
                    ADDR_DIV: begin
                        old_clock = clock_q;
                        clock_q = '0;
                        if (control_q[ENABLE_IDX] && watched_bit(old_clock, control_q))
                            step_counter();
                    end
                    ADDR_CNT: counter_q = data;
                    ADDR_MOD: modulo_q = data;
                    default: begin
                        old_control = control_q;
                        control_q = data;
                        if (old_control[ENABLE_IDX] && watched_bit(clock_q, old_control)
                                && !watched_bit(clock_q, data))
                            step_counter();
                    end
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("Mismatch on result %0d: %s is 0x%0h, expected 0x%0h.",
                 results_seen, field, got, want);
        error_count++;
    endtask

    // Drives one item and records its expected result once the transfer happens.
    task automatic send_item(input logic [1:0] op, input addr_t addr, input logic [7:0] data);
        int      gap;
        result_t res;
        gap = draw_wait();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, data, addr};
        do @(posedge aclk); while (!s_tready);
        predict_timer(op, addr, data, res);
        expected_results.push_back(res);
        items_sent++;
    endtask

    task automatic tick(input int count);
        repeat (count) send_item(OP_TICK, addr_t'($urandom_range(0, 3)), 8'($urandom));
    endtask

    task automatic read_reg(input addr_t addr);
        send_item(OP_READ, addr, 8'($urandom));
    endtask

    task automatic write_reg(input addr_t addr, input logic [7:0] data);
        send_item(OP_WRITE, addr, data);
    endtask

    initial begin : result_checker
        int      stall;
        result_t want;
        forever begin
            stall = draw_wait();
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_tvalid && m_tready));
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("Unexpected result 0x%0h with nothing outstanding.", m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[7:0] !== want.read_data)
                    report_mismatch("read_data", m_tdata[7:0], want.read_data);
                if (m_tdata[8] !== want.timer_interrupt)
                    report_mismatch("timer_interrupt", m_tdata[8], want.timer_interrupt);
                if (want.timer_interrupt)
                    interrupts_seen++;
            end
        end
    end

    task automatic test_reset_values();
        read_reg(ADDR_DIV);
        read_reg(ADDR_CNT);
        read_reg(ADDR_MOD);
        read_reg(ADDR_CTRL);
    endtask

    // Fast mode, counter at its top: the falling edge overflows and the next tick reloads.
    task automatic test_overflow_reload();
        write_reg(ADDR_CTRL, 8'h05);
        write_reg(ADDR_MOD, 8'hAB);
        write_reg(ADDR_CNT, 8'hFF);
        tick(5);
        read_reg(ADDR_CNT);
    endtask

    task automatic test_divider_write_edge();
        tick(1);
        write_reg(ADDR_DIV, 8'h5A);
        read_reg(ADDR_CNT);
        read_reg(ADDR_DIV);
    endtask

    task automatic test_control_write_edge();
        tick(2);
        write_reg(ADDR_CTRL, 8'h00);
        read_reg(ADDR_CNT);
    endtask

    task automatic test_extremes_and_unused_op();
        write_reg(ADDR_CTRL, 8'hFF);
        read_reg(ADDR_CTRL);
        send_item(OP_UNUSED, ADDR_CTRL, 8'hFF);
    endtask

    // Random program, set up so that overflows and edge effects happen often.
    task automatic run_timer_burst();
        int ticks;
        write_reg(ADDR_MOD, 8'($urandom));
        write_reg(ADDR_CTRL, {5'($urandom), ($urandom_range(0, 4) != 0), 2'($urandom)});
        write_reg(ADDR_CNT, ($urandom_range(0, 2) != 0) ? 8'($urandom_range(8'hF0, 8'hFF))
                                                          : 8'($urandom));
        ticks = $urandom_range(1, 60);
        for (int i = 0; i < ticks; i++) begin
            case ($urandom_range(0, 19))
                0:       read_reg(addr_t'($urandom_range(0, 3)));
                1:       write_reg(ADDR_DIV, 8'($urandom));
                2:       write_reg(ADDR_CTRL, 8'($urandom));
                default: tick(1);
            endcase
        end
        read_reg(ADDR_CNT);
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            tick(1);
        else if (pick < 70)
            read_reg(addr_t'($urandom_range(0, 3)));
        else if (pick < 95)
            write_reg(addr_t'($urandom_range(0, 3)), 8'($urandom));
        else
            send_item(OP_UNUSED, addr_t'($urandom_range(0, 3)), 8'($urandom));
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int next_switch;
        stop_at = items_sent + RANDOM_ITEMS;
        next_switch = items_sent;
        while (items_sent < stop_at) begin
            if (items_sent >= next_switch) begin
                no_idle = ($urandom_range(0, 3) == 0);
                next_switch = items_sent + $urandom_range(50, 200);
            end
            if ($urandom_range(0, 9) < 7)
                run_timer_burst();
            else
                send_random_item();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        reset_timer_model();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_overflow_reload();
        test_divider_write_edge();
        test_control_write_edge();
        test_extremes_and_unused_op();
        test_random_traffic();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d ticks, reads, writes and unused operations; checked %0d results.",
                 items_sent, results_seen);
        $display("Saw %0d timer interrupts, with edge effects from divider and control writes.",
                 interrupts_seen);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tmr_pkg.sv
rtl/tmr_core.sv
rtl/divider_timer_with_edge_glitches.sv
test/divider_timer_with_edge_glitches_tb.sv
